@@ rtl/core/ssfd_pkg.sv @@
package ssfd_pkg;

	// default configuration
	localparam int DIGITS_DEF     = 4;
	localparam int SEGMENTS_DEF   = 8;
	localparam int FRAME_BITS_DEF = 35;

	// fixed field widths
	localparam int PIN_W      = 6;
	localparam int CFG_W      = 48;
	localparam int CFG_REGS   = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int IDX_W      = 6;
	localparam int MASK_W     = 8;
	localparam int CODE_W     = 7;

	// item actions
	typedef enum logic [1:0] {
		ACT_SET_CHAR = 2'd0,
		ACT_SET_RAW  = 2'd1,
		ACT_REFRESH  = 2'd2
	} action_t;

	typedef logic [MASK_W-1:0] seg_mask_t;

	typedef struct packed {
		logic      hit;
		seg_mask_t mask;
	} font_t;

	// queue status seen by both sides
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	// ascii codes with their own pattern
	localparam logic [CODE_W-1:0] CH_ZERO    = 7'h30;
	localparam logic [CODE_W-1:0] CH_NINE    = 7'h39;
	localparam logic [CODE_W-1:0] CH_LOWER_A = 7'h61;
	localparam logic [CODE_W-1:0] CH_LOWER_Z = 7'h7A;
	localparam logic [CODE_W-1:0] CH_UPPER_A = 7'h41;
	localparam logic [CODE_W-1:0] CH_UPPER_Z = 7'h5A;
	localparam logic [CODE_W-1:0] CH_SPACE   = 7'h20;
	localparam logic [CODE_W-1:0] CH_COMMA   = 7'h2C;
	localparam logic [CODE_W-1:0] CH_SEMI    = 7'h3B;
	localparam logic [CODE_W-1:0] CH_PERIOD  = 7'h2E;
	localparam logic [CODE_W-1:0] CH_UNDER   = 7'h5F;
	localparam logic [CODE_W-1:0] CH_MINUS   = 7'h2D;
	localparam logic [CODE_W-1:0] CH_APOS    = 7'h27;
	localparam logic [CODE_W-1:0] CH_EQUAL   = 7'h3D;

	// font patterns
	localparam seg_mask_t NUMERAL_FONT [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	localparam seg_mask_t LETTER_FONT [26] = '{
		8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F, 8'h76, 8'h30, 8'h1E,
		8'h76, 8'h38, 8'h15, 8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78,
		8'h3E, 8'h1C, 8'h2A, 8'h76, 8'h6E, 8'h5B
	};

	localparam seg_mask_t PAT_BLANK = 8'h00;
	localparam seg_mask_t PAT_DOT   = 8'h80;
	localparam seg_mask_t PAT_UNDER = 8'h08;
	localparam seg_mask_t PAT_MINUS = 8'h40;
	localparam seg_mask_t PAT_APOS  = 8'h20;
	localparam seg_mask_t PAT_EQUAL = 8'h48;

	// character to segment mask, hit low for characters outside the font
	function automatic font_t font_lookup(input logic [CODE_W-1:0] code);
		font_t r;
		r = '0;
		if (code >= CH_ZERO && code <= CH_NINE) begin
			r.hit  = 1'b1;
			r.mask = NUMERAL_FONT[4'(code - CH_ZERO)];
		end else if (code >= CH_LOWER_A && code <= CH_LOWER_Z) begin
			r.hit  = 1'b1;
			r.mask = LETTER_FONT[5'(code - CH_LOWER_A)];
		end else if (code >= CH_UPPER_A && code <= CH_UPPER_Z) begin
			r.hit  = 1'b1;
			r.mask = LETTER_FONT[5'(code - CH_UPPER_A)];
		end else begin
			case (code) inside
				CH_SPACE: begin
					r.hit  = 1'b1;
					r.mask = PAT_BLANK;
				end
				CH_COMMA, CH_SEMI, CH_PERIOD: begin
					r.hit  = 1'b1;
					r.mask = PAT_DOT;
				end
				CH_UNDER: begin
					r.hit  = 1'b1;
					r.mask = PAT_UNDER;
				end
				CH_MINUS: begin
					r.hit  = 1'b1;
					r.mask = PAT_MINUS;
				end
				CH_APOS: begin
					r.hit  = 1'b1;
					r.mask = PAT_APOS;
				end
				CH_EQUAL: begin
					r.hit  = 1'b1;
					r.mask = PAT_EQUAL;
				end
				default: r = '0;
			endcase
		end
		return r;
	endfunction

endpackage

@@ rtl/core/ssfd_front.sv @@
module ssfd_front #(
	parameter int DIGITS     = ssfd_pkg::DIGITS_DEF,
	parameter int SEGMENTS   = ssfd_pkg::SEGMENTS_DEF,
	parameter int FRAME_BITS = ssfd_pkg::FRAME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [1:0]                     action,
	input  logic [1:0]                     digit,
	input  logic [ssfd_pkg::CODE_W-1:0]    char_code,
	input  logic [ssfd_pkg::MASK_W-1:0]    raw_mask,
	input  logic                           cfg_wr,
	input  logic [ssfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssfd_pkg::CFG_W-1:0]     cfg_data,
	input  ssfd_pkg::q_status_t            q_stat,
	output logic                           push,
	output logic [FRAME_BITS-1:0]          push_word
);

	ssfd_pkg::seg_mask_t             mask_q [DIGITS];
	logic [ssfd_pkg::CFG_W-1:0]      pin_map_q [ssfd_pkg::CFG_REGS];
	ssfd_pkg::font_t                 font;
	logic                            accept;
	logic                            wr_char;
	logic                            wr_raw;

	// pin map registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssfd_pkg::CFG_REGS; i++) begin
				pin_map_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			pin_map_q[cfg_index] <= cfg_data;
		end
	end

	// item decode
	always_comb begin
		accept  = start && !q_stat.full;
		font    = ssfd_pkg::font_lookup(char_code);
		wr_char = 1'b0;
		wr_raw  = 1'b0;
		push    = 1'b0;
		unique case (ssfd_pkg::action_t'(action))
			ssfd_pkg::ACT_SET_CHAR: wr_char = accept && font.hit;
			ssfd_pkg::ACT_SET_RAW:  wr_raw  = accept;
			ssfd_pkg::ACT_REFRESH:  push    = accept;
			default: ;
		endcase
	end

	// segment mask store, digits beyond the count are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIGITS; d++) begin
				mask_q[d] <= '0;
			end
		end else begin
			for (int d = 0; d < DIGITS; d++) begin
				if (digit == 2'(d)) begin
					if (wr_char) begin
						mask_q[d] <= font.mask;
					end else if (wr_raw) begin
						mask_q[d] <= raw_mask;
					end
				end
			end
		end
	end

	// output word: each lit segment sets the bit named by its pin
	always_comb begin
		for (int b = 0; b < FRAME_BITS; b++) begin
			push_word[b] = 1'b0;
			for (int d = 0; d < DIGITS; d++) begin
				for (int s = 0; s < SEGMENTS; s++) begin
					if (mask_q[d][s] &&
					    pin_map_q[d][ssfd_pkg::PIN_W*s +: ssfd_pkg::PIN_W] ==
					    ssfd_pkg::PIN_W'(b)) begin
						push_word[b] = 1'b1;
					end
				end
			end
		end
	end

endmodule

@@ rtl/core/ssfd_queue.sv @@
module ssfd_queue #(
	parameter int WIDTH = ssfd_pkg::FRAME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    wr_data,
	input  logic                pop,
	output logic [WIDTH-1:0]    rd_data,
	output ssfd_pkg::q_status_t q_stat
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	// two-entry word queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data      = entry_q[rd_ptr_q];
	assign q_stat.empty = (count_q == 2'd0);
	assign q_stat.full  = (count_q == 2'd2);

endmodule

@@ rtl/core/ssfd_back.sv @@
module ssfd_back #(
	parameter int FRAME_BITS = ssfd_pkg::FRAME_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ssfd_pkg::q_status_t         q_stat,
	input  logic [FRAME_BITS-1:0]       rd_data,
	output logic                        pop,
	output logic                        strobe,
	output logic                        data_bit,
	output logic [ssfd_pkg::IDX_W-1:0]  bit_index,
	output logic                        last
);

	localparam int CW = $clog2(FRAME_BITS + 1);

	logic                  active_q;
	logic [CW-1:0]         cnt_q;
	logic [FRAME_BITS:0]   frame_q;
	logic                  last_bit;

	// next frame loads on the final bit of the current one
	always_comb begin
		last_bit = active_q && (cnt_q == CW'(FRAME_BITS));
		pop      = !q_stat.empty && (!active_q || last_bit);
	end

	// frame shifter and bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			cnt_q    <= '0;
		end else if (last_bit) begin
			active_q <= 1'b0;
		end else if (active_q) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// preamble one sits below the word
	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= {rd_data, 1'b1};
		end else if (active_q) begin
			frame_q <= {1'b0, frame_q[FRAME_BITS:1]};
		end
	end

	assign strobe    = active_q;
	assign data_bit  = frame_q[0];
	assign bit_index = ssfd_pkg::IDX_W'(cnt_q);
	assign last      = last_bit;

endmodule

@@ rtl/core/seven_segment_serial_frame_driver.sv @@
// Seven-segment serial frame driver.
// Items enter on start when busy is low: action, digit, char_code, raw_mask.
// Set items (character or raw mask) update the digit's mask at the accept
// edge and produce no output. A refresh item snapshots the output word from
// the masks and the pin maps and queues it; the back end sends it as
// FRAME_BITS + 1 words, one per cycle: a preamble one at bit_index 0, then
// output bits 0 and up, with last on the final word. Each word is valid for
// exactly one cycle while strobe is high.
// With the serializer idle, a taken refresh is written into the queue, then
// popped into the frame shifter, which drives the first word. A frame occupies
// the serializer until its last word, which sets the refresh rate.
// Two snapshots can wait in the queue; busy is high while both slots hold one.
// Set items are taken whenever busy is low. Pin maps are written on cfg_wr
// with cfg_index 0..3; the user is to write them only while the block is idle,
// which the block leaves unchecked. Reset clears all masks and pin maps and
// empties the queue. The receiver cannot stall: output words are never held.
module seven_segment_serial_frame_driver #(
	parameter int DIGITS     = ssfd_pkg::DIGITS_DEF,
	parameter int SEGMENTS   = ssfd_pkg::SEGMENTS_DEF,
	parameter int FRAME_BITS = ssfd_pkg::FRAME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     action,
	input  logic [1:0]                     digit,
	input  logic [ssfd_pkg::CODE_W-1:0]    char_code,
	input  logic [ssfd_pkg::MASK_W-1:0]    raw_mask,
	input  logic                           cfg_wr,
	input  logic [ssfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssfd_pkg::CFG_W-1:0]     cfg_data,
	output logic                           strobe,
	output logic                           data_bit,
	output logic [ssfd_pkg::IDX_W-1:0]     bit_index,
	output logic                           last
);

	ssfd_pkg::q_status_t     q_stat;
	logic                    push;
	logic [FRAME_BITS-1:0]   push_word;
	logic                    pop;
	logic [FRAME_BITS-1:0]   rd_data;

	assign busy = q_stat.full;

	// decode, mask store and word snapshot
	ssfd_front #(
		.DIGITS     (DIGITS),
		.SEGMENTS   (SEGMENTS),
		.FRAME_BITS (FRAME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.digit     (digit),
		.char_code (char_code),
		.raw_mask  (raw_mask),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_word (push_word)
	);

	// snapshot queue
	ssfd_queue #(
		.WIDTH (FRAME_BITS)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_word),
		.pop     (pop),
		.rd_data (rd_data),
		.q_stat  (q_stat)
	);

	// serializer
	ssfd_back #(
		.FRAME_BITS (FRAME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.rd_data   (rd_data),
		.pop       (pop),
		.strobe    (strobe),
		.data_bit  (data_bit),
		.bit_index (bit_index),
		.last      (last)
	);

endmodule
